// ===== sv/ets_pkg.sv =====
// Enclosing triangle search: shared types, command codes and constants.
// Used by every module of the block; depends on nothing.
`default_nettype none

package ets_pkg;

    localparam int DEF_MAX_VERTICES  = 1024;
    localparam int DEF_MAX_TRIANGLES = 1024;
    localparam int DEF_COORD_WIDTH   = 16;

    localparam int CMD_W  = 2;
    localparam int IDX_W  = 10;
    localparam int CFG_W  = 11;
    localparam int SIDES  = 3;

    // 0.001 in units of 2^-16 (cross product scale)
    localparam int ETS_TOL = 66;

    localparam logic [CMD_W-1:0] CMD_LOAD_VTX = 2'd0;
    localparam logic [CMD_W-1:0] CMD_LOAD_TRI = 2'd1;
    localparam logic [CMD_W-1:0] CMD_QUERY    = 2'd2;

    typedef enum logic [1:0] {
        SIDE_A,
        SIDE_B,
        SIDE_C
    } t_side;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TRI,
        ST_VTX0,
        ST_VTX1,
        ST_VTX2,
        ST_SIDE,
        ST_WAIT,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic  write_vtx;
        logic  write_tri;
        logic  query_start;
        logic  tri_rd;
        logic  tri_inc;
        logic  vtx_rd_ab;
        logic  latch_ab;
        logic  vtx_rd_c;
        logic  latch_c;
        logic  issue;
        t_side side;
        logic  out_load;
        logic  out_found;
    } t_dp_cmd;

    typedef struct packed {
        logic side_valid;
        logic side_pass;
        logic tri_last;
        logic cfg_zero;
        logic out_free;
    } t_dp_stat;

endpackage

`default_nettype wire

// ===== sv/ets_side.sv =====
// Same-side test pipeline: two cross products and four tolerance dot products.
// Seven register stages, one side test accepted per cycle. Uses ets_pkg.
`default_nettype none

module ets_side #(
    parameter int COORD_WIDTH = ets_pkg::DEF_COORD_WIDTH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic signed [COORD_WIDTH-1:0] i_p1 [3],
    input  logic signed [COORD_WIDTH-1:0] i_p2 [3],
    input  logic signed [COORD_WIDTH-1:0] i_a  [3],
    input  logic signed [COORD_WIDTH-1:0] i_b  [3],
    output logic                          o_valid,
    output logic                          o_pass
);
    import ets_pkg::*;

    localparam int DW     = COORD_WIDTH + 1;
    localparam int PW     = 2 * DW;
    localparam int CRW    = PW + 1;
    localparam int H      = (CRW + 1) / 2;
    localparam int HW     = CRW - H;
    localparam int LW     = H + 1;
    localparam int SW     = 2 * CRW + 3;
    localparam int STAGES = 7;
    localparam int NX [3] = '{1, 2, 0};
    localparam int NY [3] = '{2, 0, 1};
    localparam logic signed [SW-1:0] TOLV = SW'(ETS_TOL);
    localparam logic signed [SW-1:0] TSQ  = SW'(ETS_TOL * ETS_TOL);

    logic [STAGES-1:0]         r_vld;
    logic signed [DW-1:0]      r_e  [3];
    logic signed [DW-1:0]      r_d1 [3];
    logic signed [DW-1:0]      r_d2 [3];
    logic signed [PW-1:0]      r_m  [12];
    logic signed [CRW-1:0]     r_c  [6];
    logic signed [2*HW-1:0]    r_hh [3];
    logic signed [HW+LW-1:0]   r_hl [3];
    logic signed [HW+LW-1:0]   r_lh [3];
    logic signed [2*LW-1:0]    r_ll [3];
    logic signed [SW-1:0]      r_lin4 [4];
    logic signed [SW-1:0]      r_prod [3];
    logic signed [SW-1:0]      r_lin5 [4];
    logic signed [SW-1:0]      r_base;
    logic signed [SW-1:0]      r_lin6 [4];
    logic                      r_pass;

    logic signed [SW-1:0]      ysum, ydif, tsum, tdif;
    logic signed [SW-1:0]      fin [4];
    logic                      n_pass;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[STAGES-2:0], i_valid};
        end
    end

    // differences
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            r_e[k]  <= DW'(i_b[k])  - DW'(i_a[k]);
            r_d1[k] <= DW'(i_p1[k]) - DW'(i_a[k]);
            r_d2[k] <= DW'(i_p2[k]) - DW'(i_a[k]);
        end
    end

    // cross product terms
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            r_m[2*k]     <= r_e[NX[k]] * r_d1[NY[k]];
            r_m[2*k+1]   <= r_e[NY[k]] * r_d1[NX[k]];
            r_m[6+2*k]   <= r_e[NX[k]] * r_d2[NY[k]];
            r_m[6+2*k+1] <= r_e[NY[k]] * r_d2[NX[k]];
        end
    end

    always_ff @(posedge i_clk) begin
        for (int j = 0; j < 6; j++) begin
            r_c[j] <= CRW'(r_m[2*j]) - CRW'(r_m[2*j+1]);
        end
    end

    // dot partials, split hi/lo; linear tolerance terms
    always_comb begin
        ysum = SW'(r_c[1]) + SW'(r_c[4]);
        ydif = SW'(r_c[4]) - SW'(r_c[1]);
        tsum = ysum * TOLV;
        tdif = ydif * TOLV;
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            r_hh[k] <= $signed(r_c[k][CRW-1:H]) * $signed(r_c[3+k][CRW-1:H]);
            r_hl[k] <= $signed(r_c[k][CRW-1:H]) * $signed({1'b0, r_c[3+k][H-1:0]});
            r_lh[k] <= $signed({1'b0, r_c[k][H-1:0]}) * $signed(r_c[3+k][CRW-1:H]);
            r_ll[k] <= $signed({1'b0, r_c[k][H-1:0]}) * $signed({1'b0, r_c[3+k][H-1:0]});
        end
        r_lin4[0] <= tsum + TSQ;
        r_lin4[1] <= TSQ - tsum;
        r_lin4[2] <= tdif - TSQ;
        r_lin4[3] <= -tdif - TSQ;
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            r_prod[k] <= (SW'(r_hh[k]) <<< (2 * H))
                       + ((SW'(r_hl[k]) + SW'(r_lh[k])) <<< H)
                       + SW'(r_ll[k]);
        end
        r_lin5 <= r_lin4;
    end

    always_ff @(posedge i_clk) begin
        r_base <= r_prod[0] + r_prod[1] + r_prod[2];
        r_lin6 <= r_lin5;
    end

    always_comb begin
        n_pass = 1'b0;
        for (int i = 0; i < 4; i++) begin
            fin[i] = r_base + r_lin6[i];
            n_pass = n_pass | ~fin[i][SW-1];
        end
    end

    always_ff @(posedge i_clk) begin
        r_pass <= n_pass;
    end

    assign o_valid = r_vld[STAGES-1];
    assign o_pass  = r_pass;

endmodule

`default_nettype wire

// ===== sv/ets_dp.sv =====
// Datapath: vertex and triangle stores, triangle counter, vertex hold
// registers, side test pipeline and result register. Uses ets_pkg, ets_side.
`default_nettype none

module ets_dp #(
    parameter int MAX_VERTICES  = ets_pkg::DEF_MAX_VERTICES,
    parameter int MAX_TRIANGLES = ets_pkg::DEF_MAX_TRIANGLES,
    parameter int COORD_WIDTH   = ets_pkg::DEF_COORD_WIDTH
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  ets_pkg::t_dp_cmd                  i_cmd,
    output ets_pkg::t_dp_stat                 o_stat,
    input  logic                              i_cfg_we,
    input  logic        [ets_pkg::CFG_W-1:0]  i_cfg_data,
    input  logic        [ets_pkg::IDX_W-1:0]  i_slot,
    input  logic signed [COORD_WIDTH-1:0]     i_pos_x,
    input  logic signed [COORD_WIDTH-1:0]     i_pos_y,
    input  logic signed [COORD_WIDTH-1:0]     i_pos_z,
    input  logic        [ets_pkg::IDX_W-1:0]  i_corner_a,
    input  logic        [ets_pkg::IDX_W-1:0]  i_corner_b,
    input  logic        [ets_pkg::IDX_W-1:0]  i_corner_c,
    input  logic                              i_out_ready,
    output logic                              o_out_valid,
    output logic                              o_found,
    output logic        [ets_pkg::IDX_W-1:0]  o_tri_index,
    output logic        [ets_pkg::IDX_W-1:0]  o_edge0_low,
    output logic        [ets_pkg::IDX_W-1:0]  o_edge0_high,
    output logic        [ets_pkg::IDX_W-1:0]  o_edge1_low,
    output logic        [ets_pkg::IDX_W-1:0]  o_edge1_high,
    output logic        [ets_pkg::IDX_W-1:0]  o_edge2_low,
    output logic        [ets_pkg::IDX_W-1:0]  o_edge2_high
);
    import ets_pkg::*;

    localparam int W   = COORD_WIDTH;
    localparam int VW  = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int TW  = (MAX_TRIANGLES > 1) ? $clog2(MAX_TRIANGLES) : 1;
    localparam int CW  = $clog2(MAX_TRIANGLES + 1);
    localparam int TRW = 3 * IDX_W;

    logic [3*W-1:0]  r_vmem [MAX_VERTICES];
    logic [TRW-1:0]  r_tmem [MAX_TRIANGLES];
    logic [3*W-1:0]  r_vq0, r_vq1;
    logic            r_oob0, r_oob1;
    logic [TRW-1:0]  r_tq;

    logic [CFG_W-1:0] r_count;
    logic [CW-1:0]    r_limit;
    logic [CW-1:0]    r_tri;

    logic signed [W-1:0] r_p  [3];
    logic signed [W-1:0] r_va [3];
    logic signed [W-1:0] r_vb [3];
    logic signed [W-1:0] r_vc [3];
    logic signed [W-1:0] s_p2 [3];
    logic signed [W-1:0] s_a  [3];
    logic signed [W-1:0] s_b  [3];

    logic             r_o_valid;
    logic             r_found;
    logic [IDX_W-1:0] r_tri_index;
    logic [IDX_W-1:0] r_e0l, r_e0h, r_e1l, r_e1h, r_e2l, r_e2h;

    logic [IDX_W-1:0] ca, cb, cc;
    logic             slot_v_ok, slot_t_ok;
    logic             side_valid, side_pass;

    assign ca = r_tq[TRW-1 -: IDX_W];
    assign cb = r_tq[2*IDX_W-1 -: IDX_W];
    assign cc = r_tq[IDX_W-1:0];

    assign slot_v_ok = 32'(i_slot) < 32'(MAX_VERTICES);
    assign slot_t_ok = 32'(i_slot) < 32'(MAX_TRIANGLES);

    // vertex store: one write, two registered reads
    always_ff @(posedge i_clk) begin
        if (i_cmd.write_vtx && slot_v_ok) begin
            r_vmem[VW'(i_slot)] <= {i_pos_x, i_pos_y, i_pos_z};
        end
        if (i_cmd.vtx_rd_ab) begin
            r_vq0  <= r_vmem[VW'(ca)];
            r_vq1  <= r_vmem[VW'(cb)];
            r_oob0 <= 32'(ca) >= 32'(MAX_VERTICES);
            r_oob1 <= 32'(cb) >= 32'(MAX_VERTICES);
        end else if (i_cmd.vtx_rd_c) begin
            r_vq0  <= r_vmem[VW'(cc)];
            r_oob0 <= 32'(cc) >= 32'(MAX_VERTICES);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.write_tri && slot_t_ok) begin
            r_tmem[TW'(i_slot)] <= {i_corner_a, i_corner_b, i_corner_c};
        end
        if (i_cmd.tri_rd) begin
            r_tq <= r_tmem[r_tri[TW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cfg_we) begin
            r_count <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.query_start) begin
            r_limit <= (32'(r_count) < 32'(MAX_TRIANGLES)) ? CW'(r_count)
                                                             : CW'(MAX_TRIANGLES);
            r_tri   <= '0;
            r_p[0]  <= i_pos_x;
            r_p[1]  <= i_pos_y;
            r_p[2]  <= i_pos_z;
        end else if (i_cmd.tri_inc) begin
            r_tri   <= r_tri + CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            if (i_cmd.latch_ab) begin
                r_va[k] <= r_oob0 ? '0 : $signed(r_vq0[(3-k)*W-1 -: W]);
                r_vb[k] <= r_oob1 ? '0 : $signed(r_vq1[(3-k)*W-1 -: W]);
            end
            if (i_cmd.latch_c) begin
                r_vc[k] <= r_oob0 ? '0 : $signed(r_vq0[(3-k)*W-1 -: W]);
            end
        end
    end

    always_comb begin
        case (i_cmd.side)
            SIDE_A: begin
                s_p2 = r_va; s_a = r_vb; s_b = r_vc;
            end
            SIDE_B: begin
                s_p2 = r_vb; s_a = r_va; s_b = r_vc;
            end
            SIDE_C: begin
                s_p2 = r_vc; s_a = r_va; s_b = r_vb;
            end
            default: begin
                s_p2 = r_va; s_a = r_vb; s_b = r_vc;
            end
        endcase
    end

    ets_side #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_side (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_cmd.issue),
        .i_p1    (r_p),
        .i_p2    (s_p2),
        .i_a     (s_a),
        .i_b     (s_b),
        .o_valid (side_valid),
        .o_pass  (side_pass)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_o_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_found <= i_cmd.out_found;
            if (i_cmd.out_found) begin
                r_tri_index <= IDX_W'(r_tri);
                r_e0l <= (ca < cb) ? ca : cb;
                r_e0h <= (ca < cb) ? cb : ca;
                r_e1l <= (cb < cc) ? cb : cc;
                r_e1h <= (cb < cc) ? cc : cb;
                r_e2l <= (cc < ca) ? cc : ca;
                r_e2h <= (cc < ca) ? ca : cc;
            end else begin
                r_tri_index <= '0;
                r_e0l <= '0;
                r_e0h <= '0;
                r_e1l <= '0;
                r_e1h <= '0;
                r_e2l <= '0;
                r_e2h <= '0;
            end
        end
    end

    always_comb begin
        o_stat.side_valid = side_valid;
        o_stat.side_pass  = side_pass;
        o_stat.tri_last   = ({1'b0, r_tri} + (CW+1)'(1)) == {1'b0, r_limit};
        o_stat.cfg_zero   = (r_count == '0);
        o_stat.out_free   = !r_o_valid || i_out_ready;
    end

    assign o_out_valid  = r_o_valid;
    assign o_found      = r_found;
    assign o_tri_index  = r_tri_index;
    assign o_edge0_low  = r_e0l;
    assign o_edge0_high = r_e0h;
    assign o_edge1_low  = r_e1l;
    assign o_edge1_high = r_e1h;
    assign o_edge2_low  = r_e2l;
    assign o_edge2_high = r_e2h;

endmodule

`default_nettype wire

// ===== sv/ets_ctrl.sv =====
// Controller: decodes transactions, sequences store reads and side tests per
// triangle, collects side results and hands off the result. Uses ets_pkg.
`default_nettype none

module ets_ctrl (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    input  logic        [ets_pkg::CMD_W-1:0] i_cmd,
    input  ets_pkg::t_dp_stat               i_stat,
    output logic                            o_in_ready,
    output ets_pkg::t_dp_cmd                o_cmd
);
    import ets_pkg::*;

    t_state     r_state, n_state;
    t_side      r_side, n_side;
    logic [1:0] r_res_cnt, n_res_cnt;
    logic       r_all, n_all;
    logic       r_found, n_found;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_side    <= SIDE_A;
            r_res_cnt <= '0;
            r_all     <= 1'b0;
            r_found   <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_side    <= n_side;
            r_res_cnt <= n_res_cnt;
            r_all     <= n_all;
            r_found   <= n_found;
        end
    end

    always_comb begin
        n_state   = r_state;
        n_side    = r_side;
        n_res_cnt = r_res_cnt;
        n_all     = r_all;
        n_found   = r_found;
        o_cmd     = '0;
        o_cmd.side = r_side;
        o_in_ready = (r_state == ST_IDLE);

        if (i_stat.side_valid) begin
            n_res_cnt = r_res_cnt + 2'd1;
            n_all     = r_all & i_stat.side_pass;
        end

        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    case (i_cmd)
                        CMD_LOAD_VTX: o_cmd.write_vtx = 1'b1;
                        CMD_LOAD_TRI: o_cmd.write_tri = 1'b1;
                        CMD_QUERY: begin
                            o_cmd.query_start = 1'b1;
                            if (i_stat.cfg_zero) begin
                                n_found = 1'b0;
                                n_state = ST_DONE;
                            end else begin
                                n_state = ST_TRI;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_TRI: begin
                o_cmd.tri_rd = 1'b1;
                n_state = ST_VTX0;
            end
            ST_VTX0: begin
                o_cmd.vtx_rd_ab = 1'b1;
                n_state = ST_VTX1;
            end
            ST_VTX1: begin
                o_cmd.latch_ab = 1'b1;
                o_cmd.vtx_rd_c = 1'b1;
                n_state = ST_VTX2;
            end
            ST_VTX2: begin
                o_cmd.latch_c = 1'b1;
                n_side    = SIDE_A;
                n_res_cnt = '0;
                n_all     = 1'b1;
                n_state   = ST_SIDE;
            end
            ST_SIDE: begin
                o_cmd.issue = 1'b1;
                case (r_side)
                    SIDE_A: n_side = SIDE_B;
                    SIDE_B: n_side = SIDE_C;
                    default: begin
                        n_side  = SIDE_A;
                        n_state = ST_WAIT;
                    end
                endcase
            end
            ST_WAIT: begin
                if (r_res_cnt == 2'(SIDES)) begin
                    if (r_all) begin
                        n_found = 1'b1;
                        n_state = ST_DONE;
                    end else if (i_stat.tri_last) begin
                        n_found = 1'b0;
                        n_state = ST_DONE;
                    end else begin
                        o_cmd.tri_inc = 1'b1;
                        n_state = ST_TRI;
                    end
                end
            end
            ST_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load  = 1'b1;
                    o_cmd.out_found = r_found;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

endmodule

`default_nettype wire

// ===== sv/enclosing_triangle_search_unit.sv =====
// Top level of the enclosing triangle search block: controller plus datapath.
// Depends on ets_pkg, ets_ctrl, ets_dp (and ets_side below it).
//
//  Channel | Direction | Handshake                   | Payload
//  cfg     | in        | i_cfg_we                    | i_cfg_data (triangle_count)
//  in      | in        | i_in_valid / o_in_ready     | i_cmd, i_slot, i_pos_*, i_corner_*
//  out     | out       | o_out_valid / i_out_ready   | o_found, o_tri_index, o_edge*
//
// Each tested triangle costs one triangle store read, vertex store reads of corners
// a and b and then of corner c, and three side tests through the 7-stage side
// pipeline; a query tests triangles in order up to the first hit or the last one.
// Reset is synchronous, active low; the stores need no clearing. A finished result
// waits in the output register while loads continue to be taken; a later query
// completes once it is taken.
`default_nettype none

module enclosing_triangle_search_unit #(
    parameter int MAX_VERTICES  = ets_pkg::DEF_MAX_VERTICES,
    parameter int MAX_TRIANGLES = ets_pkg::DEF_MAX_TRIANGLES,
    parameter int COORD_WIDTH   = ets_pkg::DEF_COORD_WIDTH
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic        [ets_pkg::CFG_W-1:0]  i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic        [ets_pkg::CMD_W-1:0]  i_cmd,
    input  logic        [ets_pkg::IDX_W-1:0]  i_slot,
    input  logic signed [COORD_WIDTH-1:0]     i_pos_x,
    input  logic signed [COORD_WIDTH-1:0]     i_pos_y,
    input  logic signed [COORD_WIDTH-1:0]     i_pos_z,
    input  logic        [ets_pkg::IDX_W-1:0]  i_corner_a,
    input  logic        [ets_pkg::IDX_W-1:0]  i_corner_b,
    input  logic        [ets_pkg::IDX_W-1:0]  i_corner_c,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic                              o_found,
    output logic        [ets_pkg::IDX_W-1:0]  o_tri_index,
    output logic        [ets_pkg::IDX_W-1:0]  o_edge0_low,
    output logic        [ets_pkg::IDX_W-1:0]  o_edge0_high,
    output logic        [ets_pkg::IDX_W-1:0]  o_edge1_low,
    output logic        [ets_pkg::IDX_W-1:0]  o_edge1_high,
    output logic        [ets_pkg::IDX_W-1:0]  o_edge2_low,
    output logic        [ets_pkg::IDX_W-1:0]  o_edge2_high
);
    import ets_pkg::*;

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    ets_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_cmd      (i_cmd),
        .i_stat     (dp_stat),
        .o_in_ready (o_in_ready),
        .o_cmd      (dp_cmd)
    );

    ets_dp #(
        .MAX_VERTICES  (MAX_VERTICES),
        .MAX_TRIANGLES (MAX_TRIANGLES),
        .COORD_WIDTH   (COORD_WIDTH)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (dp_cmd),
        .o_stat       (dp_stat),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data),
        .i_slot       (i_slot),
        .i_pos_x      (i_pos_x),
        .i_pos_y      (i_pos_y),
        .i_pos_z      (i_pos_z),
        .i_corner_a   (i_corner_a),
        .i_corner_b   (i_corner_b),
        .i_corner_c   (i_corner_c),
        .i_out_ready  (i_out_ready),
        .o_out_valid  (o_out_valid),
        .o_found      (o_found),
        .o_tri_index  (o_tri_index),
        .o_edge0_low  (o_edge0_low),
        .o_edge0_high (o_edge0_high),
        .o_edge1_low  (o_edge1_low),
        .o_edge1_high (o_edge1_high),
        .o_edge2_low  (o_edge2_low),
        .o_edge2_high (o_edge2_high)
    );

endmodule

`default_nettype wire

// ===== sv/ets_check.sv =====
// Port-level checks for the enclosing triangle search block, bound to the top.
// Depends on ets_pkg.
`default_nettype none

module ets_check (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_in_valid,
    input logic                           o_in_ready,
    input logic [ets_pkg::CMD_W-1:0]      i_cmd,
    input logic                           o_out_valid,
    input logic                           i_out_ready,
    input logic                           o_found,
    input logic [ets_pkg::IDX_W-1:0]      o_tri_index,
    input logic [ets_pkg::IDX_W-1:0]      o_edge0_low,
    input logic [ets_pkg::IDX_W-1:0]      o_edge0_high,
    input logic [ets_pkg::IDX_W-1:0]      o_edge1_low,
    input logic [ets_pkg::IDX_W-1:0]      o_edge1_high,
    input logic [ets_pkg::IDX_W-1:0]      o_edge2_low,
    input logic [ets_pkg::IDX_W-1:0]      o_edge2_high
);
    import ets_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_found)
            && $stable(o_tri_index))
        else $error("result changed while stalled");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_found |-> o_tri_index == '0 && o_edge0_low == '0
            && o_edge0_high == '0 && o_edge1_low == '0 && o_edge1_high == '0
            && o_edge2_low == '0 && o_edge2_high == '0)
        else $error("miss result carries nonzero fields");

    a_edge_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_edge0_low <= o_edge0_high && o_edge1_low <= o_edge1_high
            && o_edge2_low <= o_edge2_high)
        else $error("edge pair out of order");

    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && i_cmd == CMD_QUERY |=> !o_in_ready)
        else $error("ready right after a query transaction");

    a_reset_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind enclosing_triangle_search_unit ets_check u_ets_check (.*);

`default_nettype wire
